>>> rtl/serial_attribute_video_renderer_unit_defines.svh
// assertion macros for the serial attribute video renderer
`ifndef SERIAL_ATTRIBUTE_VIDEO_RENDERER_UNIT_DEFINES_SVH
`define SERIAL_ATTRIBUTE_VIDEO_RENDERER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SVR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svr assertion failed");

// next-cycle implication, checked outside reset
`define SVR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svr assertion failed");

`endif

>>> rtl/svr_pkg.sv
// shared types and constants of the serial attribute video renderer
package svr_pkg;

    localparam int CHARSET_DEPTH = 4096;
    localparam int CHARSET_AW    = $clog2(CHARSET_DEPTH);
    localparam int CHARSET_W     = 6;
    localparam int VISIBLE_LINES = 224;
    localparam int LINES_FIFTY   = 308 + 4;
    localparam int LINES_SIXTY   = 260 + 4;
    localparam int HIRES_LIMIT   = 200;
    localparam int START_FIFTY   = (LINES_FIFTY - VISIBLE_LINES) / 2;
    localparam int START_SIXTY   = (LINES_SIXTY - VISIBLE_LINES) / 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CELL    = 2'd1,
        CMD_CHARSET = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ATTR_FORE = 2'd0,
        ATTR_TEXT = 2'd1,
        ATTR_BACK = 2'd2,
        ATTR_MODE = 2'd3
    } attr_kind_t;

    typedef struct packed {
        logic       hires_fetch;
        logic       frame_start;
        logic       line_visible;
        logic [7:0] screen_line;
        logic [2:0] mode_bits;
    } status_t;

    typedef struct packed {
        logic [5:0] pattern;
        logic [2:0] fg;
        logic [2:0] bg;
        status_t    status;
    } render_t;

    typedef struct packed {
        logic [QUEUE_CW-1:0] fill;
        logic                empty;
    } queue_status_t;

endpackage

>>> rtl/svr_ram.sv
// generic single-port-write ram with registered read
module svr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/svr_front.sv
// front end: accepts items, keeps raster and attribute state, issues charset reads
module svr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [svr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [svr_pkg::IN_USER_W-1:0] s_axis_tuser,
    input  svr_pkg::queue_status_t        q_status,
    output logic                          push,
    output svr_pkg::render_t              push_item,
    output logic                          ram_we,
    output logic [svr_pkg::CHARSET_AW-1:0] ram_waddr,
    output logic [svr_pkg::CHARSET_W-1:0] ram_wdata,
    output logic [svr_pkg::CHARSET_AW-1:0] ram_raddr,
    input  logic [svr_pkg::CHARSET_W-1:0] ram_rdata
);

    // architectural state
    logic [8:0] raster_reg, raster_next;
    logic       rate_reg, rate_next;
    logic [4:0] frame_reg, frame_next;
    logic [2:0] fore_reg, fore_next;
    logic [2:0] back_reg, back_next;
    logic [2:0] flags_reg, flags_next;
    logic [2:0] mode_reg, mode_next;
    logic [2:0] row_reg, row_next;
    logic [7:0] line_reg, line_next;

    // stage aligned with the ram read
    logic             stage_valid_reg;
    logic             stage_use_ram_reg, stage_use_ram_next;
    logic             stage_mask_reg, stage_mask_next;
    svr_pkg::render_t stage_item_reg, stage_item_next;

    svr_pkg::cmd_t         cmd;
    svr_pkg::attr_kind_t   kind;
    logic [7:0]            cell_byte;
    logic [11:0]           char_addr;
    logic                  accept;
    logic [svr_pkg::QUEUE_CW:0] occupancy;
    logic [8:0]            rc_inc;
    logic [8:0]            flen;
    logic                  wrap;
    logic [8:0]            start_next;
    logic [9:0]            stop_next;
    logic                  vis_next;
    logic                  hires_now;
    logic [11:0]           char_index;

    assign cmd       = svr_pkg::cmd_t'(s_axis_tuser);
    assign cell_byte = s_axis_tdata[7:0];
    assign char_addr = s_axis_tdata[19:8];
    assign kind      = svr_pkg::attr_kind_t'(cell_byte[4:3]);

    // room for the item in flight as well as the new one
    assign occupancy = {1'b0, q_status.fill} + {{svr_pkg::QUEUE_CW{1'b0}}, stage_valid_reg};
    assign s_axis_tready = occupancy < (svr_pkg::QUEUE_CW + 1)'(svr_pkg::QUEUE_DEPTH);
    assign accept    = s_axis_tvalid && s_axis_tready;

    assign rc_inc    = raster_reg + 9'd1;
    assign flen      = rate_reg ? 9'(svr_pkg::LINES_FIFTY) : 9'(svr_pkg::LINES_SIXTY);
    assign wrap      = rc_inc >= flen;
    assign hires_now = (line_reg < 8'(svr_pkg::HIRES_LIMIT)) && mode_reg[2];

    assign char_index = {mode_reg[2], flags_reg[0], cell_byte[6:0], row_reg};
    assign ram_raddr  = char_index[svr_pkg::CHARSET_AW-1:0];
    assign ram_we     = accept && (cmd == svr_pkg::CMD_CHARSET);
    assign ram_waddr  = char_addr[svr_pkg::CHARSET_AW-1:0];
    assign ram_wdata  = cell_byte[5:0];

    always_comb
    begin
        raster_next = raster_reg;
        rate_next   = rate_reg;
        frame_next  = frame_reg;
        fore_next   = fore_reg;
        back_next   = back_reg;
        flags_next  = flags_reg;
        mode_next   = mode_reg;
        row_next    = row_reg;
        line_next   = line_reg;
        stage_use_ram_next = 1'b0;
        stage_mask_next    = frame_reg[4] | ~flags_reg[2];
        stage_item_next    = '0;

        if (accept)
        begin
            case (cmd)
                svr_pkg::CMD_TICK:
                begin
                    if (wrap)
                    begin
                        raster_next = '0;
                        frame_next  = frame_reg + 5'd1;
                        rate_next   = mode_reg[1];
                    end
                    else
                    begin
                        raster_next = rc_inc;
                    end
                end
                svr_pkg::CMD_CELL:
                begin
                    if (cell_byte[6:5] == 2'b00)
                    begin
                        case (kind)
                            svr_pkg::ATTR_FORE: fore_next = cell_byte[2:0];
                            svr_pkg::ATTR_TEXT:
                            begin
                                flags_next = cell_byte[2:0];
                                row_next   = cell_byte[1] ? line_reg[3:1] : line_reg[2:0];
                            end
                            svr_pkg::ATTR_BACK: back_next = cell_byte[2:0];
                            svr_pkg::ATTR_MODE: mode_next = cell_byte[2:0];
                            default:            mode_next = cell_byte[2:0];
                        endcase
                    end
                    else if (hires_now)
                    begin
                        stage_item_next.pattern = cell_byte[5:0] & {6{stage_mask_next}};
                    end
                    else
                    begin
                        stage_use_ram_next = 1'b1;
                    end
                    stage_item_next.fg = fore_next ^ {3{cell_byte[7]}};
                    stage_item_next.bg = back_next ^ {3{cell_byte[7]}};
                end
                default:
                begin
                end
            endcase
        end

        // visible window from the updated counter and rate
        start_next = rate_next ? 9'(svr_pkg::START_FIFTY) : 9'(svr_pkg::START_SIXTY);
        stop_next  = {1'b0, start_next} + 10'(svr_pkg::VISIBLE_LINES);
        vis_next   = (raster_next >= start_next) && ({1'b0, raster_next} < stop_next);

        if (accept && (cmd == svr_pkg::CMD_TICK) && vis_next)
        begin
            line_next  = 8'(raster_next - start_next);
            fore_next  = 3'd7;
            back_next  = 3'd0;
            flags_next = 3'd0;
            row_next   = line_next[2:0];
        end

        stage_item_next.status.hires_fetch  =
            (line_next < 8'(svr_pkg::HIRES_LIMIT)) && mode_next[2];
        stage_item_next.status.frame_start  = (cmd == svr_pkg::CMD_TICK) && wrap;
        stage_item_next.status.line_visible = vis_next;
        stage_item_next.status.screen_line  = line_next;
        stage_item_next.status.mode_bits    = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_reg      <= '0;
            rate_reg        <= 1'b1;
            frame_reg       <= '0;
            fore_reg        <= 3'd7;
            back_reg        <= '0;
            flags_reg       <= '0;
            mode_reg        <= 3'd2;
            row_reg         <= '0;
            line_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            raster_reg      <= raster_next;
            rate_reg        <= rate_next;
            frame_reg       <= frame_next;
            fore_reg        <= fore_next;
            back_reg        <= back_next;
            flags_reg       <= flags_next;
            mode_reg        <= mode_next;
            row_reg         <= row_next;
            line_reg        <= line_next;
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_use_ram_reg <= stage_use_ram_next;
        stage_mask_reg    <= stage_mask_next;
        stage_item_reg    <= stage_item_next;
    end

    // charset pattern joins the item as the ram data arrives
    always_comb
    begin
        push_item = stage_item_reg;
        if (stage_use_ram_reg)
        begin
            push_item.pattern = ram_rdata & {6{stage_mask_reg}};
        end
    end

    assign push = stage_valid_reg;

endmodule

>>> rtl/svr_queue.sv
// short fifo between the front end and the pixel back end
module svr_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  svr_pkg::render_t       push_item,
    input  logic                   pop,
    output svr_pkg::render_t       head,
    output svr_pkg::queue_status_t q_status
);

    svr_pkg::render_t entry_reg [svr_pkg::QUEUE_DEPTH];

    logic [svr_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [svr_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [svr_pkg::QUEUE_CW-1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.fill  = fill_reg;
    assign q_status.empty = (fill_reg == '0);

endmodule

>>> rtl/svr_back.sv
// back end: expands patterns into pixels and holds the output register
module svr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  svr_pkg::queue_status_t         q_status,
    input  svr_pkg::render_t               head,
    output logic                           pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [svr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic                           m_valid_reg;
    logic [svr_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic [17:0]                    pixels;

    assign pop = !q_status.empty && (!m_valid_reg || m_axis_tready);

    // pixel 0 takes the top pattern bit
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            pixels[3*k +: 3] = head.pattern[5-k] ? head.fg : head.bg;
        end
        m_data_next = {head.status.mode_bits, head.status.screen_line,
                       head.status.line_visible, head.status.frame_start,
                       head.status.hires_fetch, pixels};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

>>> rtl/serial_attribute_video_renderer_unit.sv
// top level of the serial attribute video renderer
//
// renders one screen cell byte into six 3-bit pixels per transaction, while
// raster ticks step the line counter and charset writes fill the internal
// 4096 x 6 character store. each input transaction gives exactly one output
// transaction. one transaction is taken every clock while the queue has room;
// the front end updates all raster and attribute state as it accepts each
// transaction, so a tick, a cell or a charset write may follow any other back
// to back. a result passes the charset read stage, then the queue, then the
// output register, and is held back only while the output side stalls. the
// four-entry queue lets the input keep running until it fills. the charset
// store is a block ram with no clear: reading an entry before it was written
// gives undefined pixels, so software must load the character patterns first.
module serial_attribute_video_renderer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [19:8] char_address, [23:20] zero
    input  logic [23:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] pixel_0 .. [17:15] pixel_5, [18] hires_fetch, [19] frame_start,
    // [20] line_visible, [28:21] screen_line, [31:29] mode_bits
    output logic [31:0] m_axis_tdata
);

    // front end to queue
    logic             push;
    svr_pkg::render_t push_item;

    // queue to back end
    logic                   pop;
    svr_pkg::render_t       head;
    svr_pkg::queue_status_t q_status;

    // charset store port
    logic                            ram_we;
    logic [svr_pkg::CHARSET_AW-1:0]  ram_waddr;
    logic [svr_pkg::CHARSET_W-1:0]   ram_wdata;
    logic [svr_pkg::CHARSET_AW-1:0]  ram_raddr;
    logic [svr_pkg::CHARSET_W-1:0]   ram_rdata;

    // classify, update state and look up the charset
    svr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .push_item     (push_item),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    // character pattern store
    svr_ram #(
        .WIDTH (svr_pkg::CHARSET_W),
        .DEPTH (svr_pkg::CHARSET_DEPTH)
    ) u_charset (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // decouples input acceptance from output stalls
    svr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_status  (q_status)
    );

    // pixel expansion and output register
    svr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> rtl/svr_checker.sv
// port-level checks for the serial attribute video renderer
`include "serial_attribute_video_renderer_unit_defines.svh"

module svr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result stays offered
    `SVR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // the wrap lands on line zero, above the visible window
    `SVR_ASSERT_NOW(a_wrap_invisible, m_axis_tvalid && m_axis_tdata[19], !m_axis_tdata[20])

    // only ticks wrap, and ticks draw no pixels
    `SVR_ASSERT_NOW(a_wrap_no_pixels, m_axis_tvalid && m_axis_tdata[19],
        m_axis_tdata[17:0] == 18'd0)

    // hires fetch needs the hires mode bit and a line below the limit
    `SVR_ASSERT_NOW(a_hires_mode, m_axis_tvalid && m_axis_tdata[18],
        m_axis_tdata[31] && (m_axis_tdata[28:21] < 8'd200))

endmodule

bind serial_attribute_video_renderer_unit svr_checker u_svr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/svr_render_checker.sv
`timescale 1ns / 1ps
// behavioural model package and stream checker for the serial attribute video renderer
package svr_render_model_pkg;
    import svr_pkg::*;

    // raster and attribute registers of the renderer
    typedef struct packed {
        logic [8:0] raster;
        logic       fifty;
        logic [4:0] frames;
        logic [2:0] fore;
        logic [2:0] back;
        logic [2:0] flags;   // alternate set, double height, blink from bit 0 up
        logic [2:0] mode;    // bit 1 fifty hertz, bit 2 hires
        logic [2:0] row;
        logic [7:0] line;
    } video_regs_t;

    // same layout as the output tdata, pixels[0] in the lowest bits
    typedef struct packed {
        logic [2:0]      mode_bits;
        logic [7:0]      screen_line;
        logic            line_visible;
        logic            frame_start;
        logic            hires_fetch;
        logic [5:0][2:0] pixels;
    } cell_result_t;

    function automatic video_regs_t regs_after_reset();
        video_regs_t r;
        r       = '0;
        r.fifty = 1'b1;
        r.fore  = 3'd7;
        r.mode  = 3'd2;
        return r;
    endfunction

    function automatic int unsigned frame_lines(video_regs_t r);
        return r.fifty ? LINES_FIFTY : LINES_SIXTY;
    endfunction

    function automatic int unsigned first_line(video_regs_t r);
        return (frame_lines(r) - VISIBLE_LINES) / 2;
    endfunction

    function automatic logic in_window(video_regs_t r);
        return (r.raster >= first_line(r)) && (r.raster < first_line(r) + VISIBLE_LINES);
    endfunction

    function automatic logic hires_line(video_regs_t r);
        return (r.line < HIRES_LIMIT) && r.mode[2];
    endfunction

    function automatic logic is_attribute(logic [7:0] c);
        return c[6:5] == 2'b00;
    endfunction

    // true when this cell byte takes its pattern from the charset store
    function automatic logic glyph_lookup(video_regs_t r, logic [7:0] c);
        return !is_attribute(c) && !hires_line(r);
    endfunction

    function automatic logic [CHARSET_AW-1:0] glyph_index(video_regs_t r, logic [7:0] c);
        logic [11:0] idx;
        idx = {r.mode[2], r.flags[0], c[6:0], r.row};
        return CHARSET_AW'(idx % CHARSET_DEPTH);
    endfunction

    // one transaction: updates the registers and returns the predicted result
    function automatic cell_result_t render_step(inout video_regs_t r, input cmd_t cmd,
                                                 input logic [7:0] c, input logic [5:0] glyph);
        cell_result_t res;
        logic [5:0]   pattern;
        logic [2:0]   fg;
        logic [2:0]   bg;
        int           k;
        res = '0;
        case (cmd)
            CMD_TICK:
            begin
                r.raster = r.raster + 9'd1;
                if (r.raster >= frame_lines(r))
                begin
                    r.raster        = '0;
                    r.frames        = r.frames + 5'd1;
                    r.fifty         = r.mode[1];
                    res.frame_start = 1'b1;
                end
                if (in_window(r))
                begin
                    r.line  = 8'(r.raster - first_line(r));
                    r.fore  = 3'd7;
                    r.back  = 3'd0;
                    r.flags = 3'd0;
                    r.row   = r.line[2:0];
                end
            end
            CMD_CELL:
            begin
                if (is_attribute(c))
                begin
                    case (attr_kind_t'(c[4:3]))
                        ATTR_FORE: r.fore = c[2:0];
                        ATTR_TEXT:
                        begin
                            r.flags = c[2:0];
                            r.row   = c[1] ? r.line[3:1] : r.line[2:0];
                        end
                        ATTR_BACK: r.back = c[2:0];
                        default:   r.mode = c[2:0];
                    endcase
                    pattern = '0;
                end
                else
                begin
                    pattern = hires_line(r) ? c[5:0] : glyph;
                    // blink hides the pattern in the first half of the frame cycle
                    if (r.flags[2] && !r.frames[4])
                        pattern = '0;
                end
                fg = r.fore ^ {3{c[7]}};
                bg = r.back ^ {3{c[7]}};
                for (k = 0; k < 6; k++)
                    res.pixels[k] = pattern[5 - k] ? fg : bg;
            end
            CMD_CHARSET, CMD_NONE: ;
            default: ;
        endcase
        res.hires_fetch  = hires_line(r);
        res.line_visible = in_window(r);
        res.screen_line  = r.line;
        res.mode_bits    = r.mode;
        return res;
    endfunction

endpackage

module svr_render_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int unsigned mismatch_count,
    output int unsigned results_pending
);
    import svr_pkg::*;
    import svr_render_model_pkg::*;

    video_regs_t  regs;
    logic [5:0]   charset_copy [CHARSET_DEPTH];
    cell_result_t expected_cells [$];
    cell_result_t want;
    cell_result_t got;
    cmd_t         item_cmd;
    logic [7:0]   item_byte;
    logic [11:0]  item_addr;
    logic [5:0]   glyph;
    int unsigned  bad_count;
    int unsigned  results_seen;
    int           k;

    assign mismatch_count = bad_count;

    task automatic report(input string msg);
        bad_count++;
        if (bad_count <= 10)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs = regs_after_reset();
            expected_cells.delete();
            bad_count       = 0;
            results_seen    = 0;
            results_pending <= 0;
        end
        else
        begin
            // compare first: a result never belongs to the transaction taken at this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = cell_result_t'(m_axis_tdata);
                if (expected_cells.size() == 0)
                    report($sformatf("result %0d (%h) with nothing expected",
                                     results_seen, m_axis_tdata));
                else
                begin
                    want = expected_cells.pop_front();
                    for (k = 0; k < 6; k++)
                        if (got.pixels[k] !== want.pixels[k])
                            report($sformatf("result %0d pixel_%0d: expected %0d, got %0d",
                                             results_seen, k, want.pixels[k], got.pixels[k]));
                    if (got.hires_fetch !== want.hires_fetch)
                        report($sformatf("result %0d hires_fetch: expected %0d, got %0d",
                                         results_seen, want.hires_fetch, got.hires_fetch));
                    if (got.frame_start !== want.frame_start)
                        report($sformatf("result %0d frame_start: expected %0d, got %0d",
                                         results_seen, want.frame_start, got.frame_start));
                    if (got.line_visible !== want.line_visible)
                        report($sformatf("result %0d line_visible: expected %0d, got %0d",
                                         results_seen, want.line_visible, got.line_visible));
                    if (got.screen_line !== want.screen_line)
                        report($sformatf("result %0d screen_line: expected %0d, got %0d",
                                         results_seen, want.screen_line, got.screen_line));
                    if (got.mode_bits !== want.mode_bits)
                        report($sformatf("result %0d mode_bits: expected %0d, got %0d",
                                         results_seen, want.mode_bits, got.mode_bits));
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                item_cmd  = cmd_t'(s_axis_tuser);
                item_byte = s_axis_tdata[7:0];
                item_addr = s_axis_tdata[19:8];
                glyph     = charset_copy[glyph_index(regs, item_byte)];
                if (item_cmd == CMD_CHARSET)
                    charset_copy[CHARSET_AW'(item_addr % CHARSET_DEPTH)] = item_byte[5:0];
                expected_cells.push_back(render_step(regs, item_cmd, item_byte, glyph));
            end
            results_pending <= expected_cells.size();
        end
    end

endmodule

>>> sim/tb_serial_attribute_video_renderer_unit.sv
`timescale 1ns / 1ps
// testbench top for the serial attribute video renderer: stimulus, handshake pacing and verdict
module tb_serial_attribute_video_renderer_unit;
    import svr_pkg::*;
    import svr_render_model_pkg::*;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] data_byte, [19:8] char_address, [23:20] zero
    logic [23:0] s_axis_tdata  = '0;
    // [1:0] command
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] pixel_0 .. [17:15] pixel_5, [18] hires_fetch, [19] frame_start,
    // [20] line_visible, [28:21] screen_line, [31:29] mode_bits
    logic [31:0] m_axis_tdata;

    int unsigned mismatch_count;
    int unsigned results_pending;

    // registers as they stand after every transaction issued so far; used to
    // keep cell bytes away from charset entries that were never loaded
    video_regs_t gen_regs;
    bit          glyph_loaded [CHARSET_DEPTH];

    // pacing: percentage of cycles the sender idles and the receiver stalls
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;

    int unsigned sent           = 0;
    int unsigned content_sent   = 0;
    int unsigned frames_wrapped = 0;
    int unsigned glyph_loads    = 0;

    serial_attribute_video_renderer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    svr_render_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the pipeline hangs; far beyond the slowest correct run
    initial
    begin
        #(5_000_000);
        $display("serial_attribute_video_renderer_unit regression: fail");
        $finish;
    end

    // receiver: back-pressure at the rate of the current pacing phase
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // issue one transaction and hold it until the block takes it
    task automatic push_item(input cmd_t cmd, input logic [7:0] cell_byte,
                             input logic [11:0] addr);
        cell_result_t shadow;
        // pacing phases rotate every 64 transactions: free running, sender
        // gaps, receiver stalls, then light gaps on both sides
        case ((sent / 64) % 4)
            0:
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1:
            begin
                idle_pct  = 64;
                stall_pct = 0;
            end
            2:
            begin
                idle_pct  = 0;
                stall_pct = 64;
            end
            default:
            begin
                idle_pct  = 14;
                stall_pct = 14;
            end
        endcase
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, addr, cell_byte};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        shadow = render_step(gen_regs, cmd, cell_byte, 6'd0);
        if (shadow.frame_start)
            frames_wrapped++;
        if (cmd == CMD_CHARSET)
            glyph_loaded[CHARSET_AW'(addr % CHARSET_DEPTH)] = 1'b1;
        sent++;
    endtask

    // a screen cell; the charset entry it will read is loaded first if it is still empty
    task automatic push_cell(input logic [7:0] c);
        logic [11:0] idx;
        idx = glyph_index(gen_regs, c);
        if (glyph_lookup(gen_regs, c) && !glyph_loaded[idx])
        begin
            push_item(CMD_CHARSET, 8'($urandom), idx);
            glyph_loads++;
        end
        push_item(CMD_CELL, c, 12'($urandom));
    endtask

    task automatic push_tick();
        push_item(CMD_TICK, 8'($urandom), 12'($urandom));
    endtask

    initial
    begin
        logic [7:0]  c;
        int unsigned run;
        int unsigned pick;

        gen_regs = regs_after_reset();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state on an invisible line, store extremes, unused command
        push_cell(8'h20);
        push_item(CMD_CHARSET, 8'hFF, 12'hFFF);
        push_item(CMD_CHARSET, 8'h00, 12'h000);
        push_item(CMD_NONE, 8'hFF, 12'hFFF);
        push_tick();
        // foreground, text and background attribute kinds, inverted attribute cell, blink in the first half cycle
        push_cell(8'h00);
        push_cell(8'h97);
        push_cell(8'h0F);
        push_cell(8'hFF);
        // double height row, then hires mode with pattern extremes
        push_cell(8'h0A);
        push_cell(8'h60);
        push_cell(8'h1E);
        push_cell(8'h7F);
        push_cell(8'hBF);
        push_cell(8'h40);
        // text mode at the sixty hertz setting, then back to the reset mode
        push_cell(8'h19);
        push_cell(8'hE0);
        push_cell(8'h1A);
        push_tick();

        // random part: raster lines with a few cells each, until the item budget is spent
        while (sent < 550)
        begin
            if ($urandom_range(0, 3) == 0)
                run = $urandom_range(2, 40);
            else
                run = 1;
            repeat (run) push_tick();
            repeat ($urandom_range(0, 6))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    push_cell({1'($urandom), 2'b00, 5'($urandom)});
                else if (pick < 85)
                begin
                    c = 8'($urandom);
                    if (c[6:5] == 2'b00)
                        c[5] = 1'b1;
                    push_cell(c);
                end
                else if (pick < 95)
                    push_item(CMD_CHARSET, 8'($urandom), 12'($urandom));
                else
                    push_item(CMD_NONE, 8'($urandom), 12'($urandom));
                content_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then leave room for any stray result
        do
            @(posedge clk);
        while (results_pending != 0);
        repeat (20) @(posedge clk);

        $display("run covered %0d transactions: %0d cells, writes and idle commands,",
                 sent, content_sent);
        $display("%0d glyph loads, %0d frame wraps, %0d field mismatches, %0d results missing",
                 glyph_loads, frames_wrapped, mismatch_count, results_pending);
        if (mismatch_count == 0 && results_pending == 0)
            $display("serial_attribute_video_renderer_unit regression: pass");
        else
            $display("serial_attribute_video_renderer_unit regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/svr_pkg.sv
rtl/svr_ram.sv
rtl/svr_front.sv
rtl/svr_queue.sv
rtl/svr_back.sv
rtl/serial_attribute_video_renderer_unit.sv
rtl/svr_checker.sv
sim/svr_render_checker.sv
sim/tb_serial_attribute_video_renderer_unit.sv
